### rtl/ngp_pkg.sv
// Shared types, character codes and helper functions for the NMEA GGA/GSA parser.
package ngp_pkg;

  // Character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_A      = 8'h41;

  // Field positions and saturation limits
  localparam logic [4:0] GGA_FIX_COMMA  = 5'd6;
  localparam logic [4:0] GSA_PDOP_COMMA = 5'd15;
  localparam logic [4:0] COMMA_SAT      = 5'd31;
  localparam logic [7:0] LEN_SAT        = 8'hFF;
  localparam logic [2:0] PDOP_CHARS     = 3'd4;

  // Phase within one sentence; the sentence kind is held separately
  typedef enum logic [3:0] {
    PH_HUNT = 4'd0,
    PH_TAG1 = 4'd1,
    PH_TAG2 = 4'd2,
    PH_TAG3 = 4'd3,
    PH_TAG4 = 4'd4,
    PH_TAG5 = 4'd5,
    PH_DATA = 4'd6,
    PH_CAPT = 4'd7,
    PH_CK0  = 4'd8,
    PH_CK1  = 4'd9
  } ngp_phase_t;

  // Complete parser context
  typedef struct packed {
    logic        gsa;
    ngp_phase_t  phase;
    logic [7:0]  run_xor;
    logic [7:0]  length;
    logic [4:0]  commas;
    logic [2:0]  pdop_idx;
    logic [7:0]  fix;
    logic [31:0] pdop;
    logic [3:0]  ck_hi;
  } ngp_ctx_t;

  // Per-beat result
  typedef struct packed {
    logic [7:0]  echo_byte;
    logic        keep;
    logic        which_sentence;
    logic        sentence_begin;
    logic        gga_valid;
    logic        pair_done;
    logic        dropped;
    logic [7:0]  fix_char;
    logic [31:0] pdop_text;
  } ngp_result_t;

  // Decode one hex digit: bit 4 set when the character is not hex
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30;
        hex_decode = {1'b0, d[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
        d = c - 8'h37;
        hex_decode = {1'b0, d[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
        d = c - 8'h57;
        hex_decode = {1'b0, d[3:0]};
      end else begin
        hex_decode = 5'h10;
      end
    end
  endfunction

  // Expected tag character for a prefix phase
  function automatic logic [7:0] tag_char(input logic gsa, input ngp_phase_t ph);
    begin
      case (ph)
        PH_TAG1: tag_char = CH_G;
        PH_TAG2: tag_char = CH_N;
        PH_TAG3: tag_char = CH_G;
        PH_TAG4: tag_char = gsa ? CH_S : CH_G;
        PH_TAG5: tag_char = CH_A;
        default: tag_char = 8'h00;
      endcase
    end
  endfunction

endpackage

### rtl/ngp_step.sv
// Per-byte next-context and result logic of the NMEA GGA/GSA parser.
module ngp_step #(
  parameter int MAX_SENTENCE = 128
) (
  input  ngp_pkg::ngp_ctx_t    ctx,
  input  logic [7:0]           rx_byte,
  output ngp_pkg::ngp_ctx_t    ctx_nxt,
  output ngp_pkg::ngp_result_t res
);
  import ngp_pkg::*;

  localparam logic [7:0] MaxLen = 8'(MAX_SENTENCE);

  logic [7:0] len_grown;
  logic [4:0] comma_inc;
  logic [4:0] comma_target;
  logic [2:0] pidx_inc;
  logic [4:0] hex;
  logic       keep, begin_s, good_gga, done, drop;

  assign len_grown    = (ctx.length == LEN_SAT) ? ctx.length : ctx.length + 8'd1;
  assign comma_inc    = (ctx.commas == COMMA_SAT) ? ctx.commas : ctx.commas + 5'd1;
  assign comma_target = ctx.gsa ? GSA_PDOP_COMMA : GGA_FIX_COMMA;
  assign pidx_inc     = ctx.pdop_idx + 3'd1;
  assign hex          = hex_decode(rx_byte);

  // Advance the parser by one byte
  always_comb begin
    ctx_nxt  = ctx;
    keep     = 1'b0;
    begin_s  = 1'b0;
    good_gga = 1'b0;
    done     = 1'b0;
    drop     = 1'b0;
    case (ctx.phase)
      PH_HUNT: begin
        if (rx_byte == CH_DOLLAR) begin
          keep             = 1'b1;
          begin_s          = 1'b1;
          ctx_nxt.run_xor  = 8'h00;
          ctx_nxt.length   = 8'd1;
          ctx_nxt.commas   = 5'd0;
          ctx_nxt.pdop_idx = 3'd0;
          ctx_nxt.phase    = PH_TAG1;
        end
      end
      PH_TAG1, PH_TAG2, PH_TAG3, PH_TAG4, PH_TAG5: begin
        if (rx_byte == tag_char(ctx.gsa, ctx.phase)) begin
          keep            = 1'b1;
          ctx_nxt.run_xor = ctx.run_xor ^ rx_byte;
          ctx_nxt.length  = len_grown;
          ctx_nxt.phase   = ngp_phase_t'(ctx.phase + 4'd1);
        end else begin
          drop          = 1'b1;
          ctx_nxt.phase = PH_HUNT;
        end
      end
      PH_DATA, PH_CAPT: begin
        keep           = 1'b1;
        ctx_nxt.length = len_grown;
        if (ctx.phase == PH_DATA && rx_byte == CH_STAR) begin
          ctx_nxt.phase = PH_CK0;
        end else begin
          ctx_nxt.run_xor = ctx.run_xor ^ rx_byte;
          if (ctx.phase == PH_DATA) begin
            if (rx_byte == CH_COMMA) begin
              ctx_nxt.commas = comma_inc;
              if (comma_inc == comma_target) begin
                ctx_nxt.pdop_idx = 3'd0;
                ctx_nxt.phase    = PH_CAPT;
              end
            end
          end else if (!ctx.gsa) begin
            ctx_nxt.fix   = rx_byte;
            ctx_nxt.phase = PH_DATA;
          end else begin
            ctx_nxt.pdop     = {ctx.pdop[23:0], rx_byte};
            ctx_nxt.pdop_idx = pidx_inc;
            if (pidx_inc >= PDOP_CHARS) begin
              ctx_nxt.pdop_idx = 3'd0;
              ctx_nxt.phase    = PH_DATA;
            end
          end
          // Drop on buffer overflow; this wins over a capture
          if (len_grown >= MaxLen) begin
            drop             = 1'b1;
            ctx_nxt.pdop_idx = 3'd0;
            ctx_nxt.phase    = PH_HUNT;
          end
        end
      end
      PH_CK0: begin
        keep           = 1'b1;
        ctx_nxt.length = len_grown;
        if (hex[4]) begin
          drop          = 1'b1;
          ctx_nxt.gsa   = 1'b0;
          ctx_nxt.phase = PH_HUNT;
        end else begin
          ctx_nxt.ck_hi = hex[3:0];
          ctx_nxt.phase = PH_CK1;
        end
      end
      PH_CK1: begin
        keep           = 1'b1;
        ctx_nxt.length = len_grown;
        ctx_nxt.phase  = PH_HUNT;
        if (!hex[4] && {ctx.ck_hi, hex[3:0]} == ctx.run_xor) begin
          if (ctx.gsa) begin
            done        = 1'b1;
            ctx_nxt.gsa = 1'b0;
          end else begin
            good_gga    = 1'b1;
            ctx_nxt.gsa = 1'b1;
          end
        end else begin
          drop        = 1'b1;
          ctx_nxt.gsa = 1'b0;
        end
      end
      default: begin
        ctx_nxt.gsa   = 1'b0;
        ctx_nxt.phase = PH_HUNT;
      end
    endcase
  end

  // Assemble the result beat
  always_comb begin
    res.echo_byte      = rx_byte;
    res.keep           = keep;
    res.which_sentence = ctx.gsa;
    res.sentence_begin = begin_s;
    res.gga_valid      = good_gga;
    res.pair_done      = done;
    res.dropped        = drop;
    res.fix_char       = ctx_nxt.fix;
    res.pdop_text      = ctx_nxt.pdop;
  end

endmodule

### rtl/nmea_gga_gsa_sentence_parser_core.sv
// Top level of the NMEA GGA/GSA sentence pair parser.
//
// Usage: feed received serial characters on the in_ channel (in_rx_byte),
// one beat per character. Every input beat yields exactly one out_ beat that
// echoes the character with its buffer-keep, sentence select and start marks,
// the GGA checksum match, pair-complete and drop flags, and the latest
// captured fix character and four PDOP characters.
// Timing: a result is registered and appears in the cycle after its input beat is accepted.
// Throughput: one character per cycle while the output is not stalled; the
// parser context is registered from each accepted byte, and the result sits
// in one output register.
// Stall: while out_ready is low the result holds; in_ready stays high as long
// as the output register is empty or being emptied in the same cycle.
// Reset: rst_n (synchronous, active low) returns the parser to the GGA hunt
// with all checksum, counts and captures cleared, and empties the output.
module nmea_gga_gsa_sentence_parser_core #(
  parameter int MAX_SENTENCE = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_echo_byte,
  output logic        out_keep,
  output logic        out_which_sentence,
  output logic        out_sentence_begin,
  output logic        out_gga_valid,
  output logic        out_pair_done,
  output logic        out_dropped,
  output logic [7:0]  out_fix_char,
  output logic [31:0] out_pdop_text
);
  import ngp_pkg::*;

  ngp_ctx_t    ctx_r, ctx_nxt;
  ngp_result_t res_nxt, res_r;
  logic        out_valid_r, out_valid_nxt;
  logic        in_acc;

  // Accept while the output register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  ngp_step #(
    .MAX_SENTENCE(MAX_SENTENCE)
  ) u_step (
    .ctx     (ctx_r),
    .rx_byte (in_rx_byte),
    .ctx_nxt (ctx_nxt),
    .res     (res_nxt)
  );

  // Parser context: advance on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= '0;
    end else if (in_acc) begin
      ctx_r <= ctx_nxt;
    end
  end

  // Output valid: set on accept, clear when taken
  assign out_valid_nxt = in_acc || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_echo_byte      = res_r.echo_byte;
  assign out_keep           = res_r.keep;
  assign out_which_sentence = res_r.which_sentence;
  assign out_sentence_begin = res_r.sentence_begin;
  assign out_gga_valid      = res_r.gga_valid;
  assign out_pair_done      = res_r.pair_done;
  assign out_dropped        = res_r.dropped;
  assign out_fix_char       = res_r.fix_char;
  assign out_pdop_text      = res_r.pdop_text;

endmodule

### rtl/ngp_checker.sv
// Port-level checker for the NMEA GGA/GSA parser, bound to the top level.
module ngp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_rx_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_echo_byte,
  input logic        out_keep,
  input logic        out_which_sentence,
  input logic        out_sentence_begin,
  input logic        out_gga_valid,
  input logic        out_pair_done,
  input logic        out_dropped,
  input logic [7:0]  out_fix_char,
  input logic [31:0] out_pdop_text
);
  import ngp_pkg::*;

  // Stalled result beat holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid
      && $stable({out_echo_byte, out_keep, out_which_sentence, out_sentence_begin,
                  out_gga_valid, out_pair_done, out_dropped, out_fix_char,
                  out_pdop_text}))
    else $error("stalled result beat changed");

  // Every accepted byte gives a result beat in the next cycle, echoing it
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid && out_echo_byte == $past(in_rx_byte))
    else $error("accepted byte produced no matching result");

  // At most one outcome flag per beat
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_gga_valid, out_pair_done, out_dropped,
                            out_sentence_begin}))
    else $error("conflicting outcome flags");

  // A sentence start is a kept dollar
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sentence_begin |-> out_keep && out_echo_byte == CH_DOLLAR)
    else $error("sentence start on a byte other than a kept dollar");

  // Pair completion only in the GSA phase, GGA match only in the GGA phase
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pair_done || out_gga_valid) |->
      out_keep && (out_which_sentence == out_pair_done))
    else $error("checksum outcome in the wrong sentence phase");

endmodule

bind nmea_gga_gsa_sentence_parser_core ngp_checker u_ngp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_rx_byte         (in_rx_byte),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_echo_byte      (out_echo_byte),
  .out_keep           (out_keep),
  .out_which_sentence (out_which_sentence),
  .out_sentence_begin (out_sentence_begin),
  .out_gga_valid      (out_gga_valid),
  .out_pair_done      (out_pair_done),
  .out_dropped        (out_dropped),
  .out_fix_char       (out_fix_char),
  .out_pdop_text      (out_pdop_text)
);
